### design/bms_pkg.sv
`timescale 1ns / 1ps

package bms_pkg;

  localparam int REG_BITS  = 16;
  localparam int MEM_DEPTH = 1 << REG_BITS;

  typedef logic [REG_BITS-1:0]      reg_t;
  typedef logic [3:0][REG_BITS-1:0] regs_t;
  typedef logic [7:0]               byte_t;

  localparam logic [2:0] OP_MOVE   = 3'd0;
  localparam logic [2:0] OP_PUSH   = 3'd1;
  localparam logic [2:0] OP_CSUBZ  = 3'd2;
  localparam logic [2:0] OP_CSUBNZ = 3'd3;
  localparam logic [2:0] OP_AND    = 3'd4;
  localparam logic [2:0] OP_XOR    = 3'd5;
  localparam logic [2:0] OP_ADD    = 3'd6;
  localparam logic [2:0] OP_SUB    = 3'd7;

  localparam byte_t HALT_B0 = 8'hff;
  localparam byte_t HALT_B1 = 8'h02;

  typedef struct packed {
    logic  en;
    reg_t  addr;
    byte_t data;
  } store_t;

endpackage

### design/bms_ram.sv
`timescale 1ns / 1ps

module bms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

### design/bms_alu.sv
`timescale 1ns / 1ps

module bms_alu (
  input  bms_pkg::byte_t  ins_i,
  input  bms_pkg::regs_t  regs_i,
  input  bms_pkg::byte_t  opnd_i,
  output bms_pkg::regs_t  regs_o,
  output bms_pkg::store_t store_o
);

  import bms_pkg::*;

  logic [2:0] op;
  logic       memop;
  logic [1:0] rd;
  logic [1:0] ra;
  byte_t      b;
  reg_t       bsx;
  reg_t       bzx;
  reg_t       dec;
  reg_t       src;

  assign op    = ins_i[7:5];
  assign memop = ins_i[4];
  assign rd    = ins_i[3:2];
  assign ra    = ins_i[1:0];
  assign b     = memop ? opnd_i : regs_i[ra][7:0];
  assign bsx   = REG_BITS'($signed(b));
  assign bzx   = REG_BITS'(b);
  assign dec   = regs_i[rd] - reg_t'(1);
  assign src   = (rd == ra) ? dec : regs_i[ra];

  always_comb begin
    regs_o  = regs_i;
    store_o = '0;
    case (op)
      OP_MOVE: begin
        regs_o[rd] = memop ? ((regs_i[rd] << 8) | bzx) : regs_i[ra];
      end
      OP_PUSH: begin
        regs_o[rd]   = dec;
        store_o.en   = 1'b1;
        store_o.addr = dec;
        if (memop) begin
          store_o.data = opnd_i;
        end else begin
          store_o.data = src[7:0];
          regs_o[ra]   = src >> 8;
        end
      end
      OP_CSUBZ: begin
        if (regs_i[0][7:0] == 8'h00) regs_o[rd] = regs_i[rd] - bsx;
      end
      OP_CSUBNZ: begin
        if (regs_i[0][7:0] != 8'h00) regs_o[rd] = regs_i[rd] - bsx;
      end
      OP_AND: begin
        regs_o[rd] = regs_i[rd] & (~reg_t'(8'hff) | bzx);
      end
      OP_XOR: begin
        regs_o[rd] = regs_i[rd] ^ bzx;
      end
      OP_ADD: begin
        regs_o[rd] = regs_i[rd] + bsx;
      end
      OP_SUB: begin
        regs_o[rd] = regs_i[rd] - bsx;
      end
      default: begin
        regs_o = regs_i;
      end
    endcase
  end

endmodule

### design/byte_machine_step.sv
`timescale 1ns / 1ps
// Byte machine: each input item either loads one byte into the byte memory
// (operation_i = 0) or executes the instruction at the pc (operation_i = 1).
// Every item yields exactly one result item: pc after the item, the executed
// instruction, any byte stored by a push, and the halt flag (FF 02 at pc).
// Input: in_valid_i / in_stall_o with a one-item input buffer, so an item is
// taken while the previous one is still at work. Output: out_valid_o /
// out_stall_i from an output register; the next result is computed while the
// current one waits and is held until the receiver takes it.
// Steps: an execute item goes through operand read, execute and write, and
// halt-byte read; a load through write and halt-byte read. The instruction
// byte at the pc is kept from the previous halt read, so no fetch step is
// needed. Items are worked one at a time, the next waiting in the buffer;
// the rate is bounded by the memory reads in the dependent chain. The result
// enters the output register from DONE, or from HOLD if it was still full.
// Reset: state, valid flags, registers and cached byte go to zero, the clear
// flag is set, then the memory is cleared one byte a cycle; no item is taken
// from the buffer during that pass. A stalled receiver stops the block once
// one result waits in the output register and a finished one is held back.

module byte_machine_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [15:0]           load_address_i,
  input  logic [7:0]            load_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  halted_o,
  output logic [15:0]           program_counter_o,
  output logic [7:0]            instruction_o,
  output logic                  wrote_memory_o,
  output logic [15:0]           write_address_o,
  output logic [7:0]            write_data_o
);

  import bms_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXE  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0] state_q, state_d;
  logic       clearing_q, clearing_d;
  reg_t       clr_addr_q, clr_addr_d;
  logic       in_full_q, in_full_d;
  logic       in_op_q;
  reg_t       in_addr_q;
  byte_t      in_byte_q;
  regs_t      regs_q, regs_d;
  byte_t      cache_q, cache_d;
  byte_t      ins_q, ins_d;
  store_t     fwd_q, fwd_d;
  byte_t      res_ins_q, res_ins_d;
  store_t     res_st_q, res_st_d;
  logic       halt_hold_q, halt_hold_d;
  logic       out_valid_q, out_valid_d;
  logic       halted_q, halted_d;
  reg_t       out_pc_q, out_pc_d;
  byte_t      out_ins_q, out_ins_d;
  store_t     out_st_q, out_st_d;

  logic       accept;
  logic       take;
  logic       out_free;
  logic [1:0] ra;
  reg_t       pc_inc;
  reg_t       a_val;
  regs_t      regs_f;
  regs_t      alu_regs;
  store_t     alu_st;
  byte_t      rdata_a;
  byte_t      rdata_b;
  byte_t      hb0;
  byte_t      hb1;
  logic       halt_now;
  logic       emit;
  logic       ram_we;
  reg_t       ram_waddr;
  byte_t      ram_wdata;
  reg_t       ram_raddr_a;
  reg_t       ram_raddr_b;

  assign take       = in_full_q && !clearing_q && (state_q == ST_IDLE);
  assign in_stall_o = in_full_q && !take;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign ra     = cache_q[1:0];
  assign pc_inc = regs_q[3] + reg_t'(1);

  always_comb begin
    regs_f    = regs_q;
    regs_f[3] = pc_inc;
  end

  assign a_val = regs_f[ra];

  bms_alu u_alu (
    .ins_i   (ins_q),
    .regs_i  (regs_q),
    .opnd_i  (rdata_a),
    .regs_o  (alu_regs),
    .store_o (alu_st)
  );

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = alu_st.addr;
    ram_wdata   = alu_st.data;
    ram_raddr_a = a_val;
    ram_raddr_b = regs_q[3] + reg_t'(1);
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (take && !in_op_q) begin
      ram_we      = 1'b1;
      ram_waddr   = in_addr_q;
      ram_wdata   = in_byte_q;
      ram_raddr_a = regs_q[3];
    end else if (state_q == ST_EXE) begin
      ram_we      = alu_st.en;
      ram_raddr_a = alu_regs[3];
      ram_raddr_b = alu_regs[3] + reg_t'(1);
    end
  end

  bms_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (rdata_b)
  );

  // forward the byte written alongside the halt reads
  assign hb0 = (fwd_q.en && fwd_q.addr == regs_q[3]) ? fwd_q.data : rdata_a;
  assign hb1 = (fwd_q.en && fwd_q.addr == pc_inc) ? fwd_q.data : rdata_b;
  assign halt_now = (hb0 == HALT_B0) && (hb1 == HALT_B1);

  always_comb begin
    state_d     = state_q;
    clearing_d  = clearing_q;
    clr_addr_d  = clr_addr_q;
    in_full_d   = take ? accept : (in_full_q || accept);
    regs_d      = regs_q;
    cache_d     = cache_q;
    ins_d       = ins_q;
    fwd_d       = fwd_q;
    res_ins_d   = res_ins_q;
    res_st_d    = res_st_q;
    halt_hold_d = halt_hold_q;
    halted_d    = halted_q;
    out_pc_d    = out_pc_q;
    out_ins_d   = out_ins_q;
    out_st_d    = out_st_q;
    emit        = 1'b0;

    if (clearing_q) begin
      clr_addr_d = clr_addr_q + reg_t'(1);
      if (clr_addr_q == '1) clearing_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (!in_op_q) begin
            fwd_d.en   = 1'b1;
            fwd_d.addr = in_addr_q;
            fwd_d.data = in_byte_q;
            res_ins_d  = '0;
            res_st_d   = '0;
            state_d    = ST_DONE;
          end else begin
            ins_d     = cache_q;
            regs_d[3] = pc_inc;
            if (cache_q[4]) regs_d[ra] = a_val + reg_t'(1);
            state_d   = ST_EXE;
          end
        end
      end
      ST_EXE: begin
        regs_d    = alu_regs;
        fwd_d     = alu_st;
        res_ins_d = ins_q;
        res_st_d  = alu_st;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        cache_d = hb0;
        if (out_free) begin
          emit     = 1'b1;
          halted_d = halt_now;
          state_d  = ST_IDLE;
        end else begin
          halt_hold_d = halt_now;
          state_d     = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          emit     = 1'b1;
          halted_d = halt_hold_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_pc_d  = regs_q[3];
      out_ins_d = res_ins_q;
      out_st_d  = res_st_q;
    end
    out_valid_d = emit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      in_full_q   <= 1'b0;
      regs_q      <= '0;
      cache_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clearing_q  <= clearing_d;
      clr_addr_q  <= clr_addr_d;
      in_full_q   <= in_full_d;
      regs_q      <= regs_d;
      cache_q     <= cache_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q   <= operation_i;
      in_addr_q <= REG_BITS'(load_address_i);
      in_byte_q <= load_byte_i;
    end
    ins_q       <= ins_d;
    fwd_q       <= fwd_d;
    res_ins_q   <= res_ins_d;
    res_st_q    <= res_st_d;
    halt_hold_q <= halt_hold_d;
    halted_q    <= halted_d;
    out_pc_q    <= out_pc_d;
    out_ins_q   <= out_ins_d;
    out_st_q    <= out_st_d;
  end

  assign out_valid_o       = out_valid_q;
  assign halted_o          = halted_q;
  assign program_counter_o = 16'(out_pc_q);
  assign instruction_o     = out_ins_q;
  assign wrote_memory_o    = out_st_q.en;
  assign write_address_o   = 16'(out_st_q.addr);
  assign write_data_o      = out_st_q.data;

endmodule

### tb/byte_machine_step_checker.sv
`timescale 1ns / 1ps

module byte_machine_step_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        operation_i,
  input  logic [15:0] load_address_i,
  input  logic [7:0]  load_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        halted_i,
  input  logic [15:0] program_counter_i,
  input  logic [7:0]  instruction_i,
  input  logic        wrote_memory_i,
  input  logic [15:0] write_address_i,
  input  logic [7:0]  write_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output logic [15:0] last_pc_o
);

  import bms_pkg::*;

  typedef struct packed {
    logic        halted;
    logic [15:0] pc;
    byte_t       ins;
    logic        wrote;
    logic [15:0] waddr;
    byte_t       wdata;
  } step_report_t;

  byte_t        mem_q [MEM_DEPTH];
  reg_t         regs_q [4];
  step_report_t step_reports_q [$];
  int           fail_count = 0;

  initial begin
    foreach (mem_q[i]) mem_q[i] = '0;
    foreach (regs_q[i]) regs_q[i] = '0;
  end

  // memory operand, post-increments its address register
  function automatic byte_t take_operand(input logic [1:0] ra);
    byte_t b;
    b = mem_q[regs_q[ra]];
    regs_q[ra] = regs_q[ra] + 1'b1;
    return b;
  endfunction

  task automatic run_machine_step(input logic is_exec, input logic [15:0] addr,
                                  input byte_t data);
    step_report_t rep;
    byte_t        ins;
    byte_t        b;
    logic [2:0]   opc;
    logic         memop;
    logic [1:0]   rd;
    logic [1:0]   ra;
    reg_t         sb;
    reg_t         pc;
    rep = '0;
    if (!is_exec) begin
      mem_q[reg_t'(addr)] = data;
    end else begin
      ins = mem_q[regs_q[3]];
      regs_q[3] = regs_q[3] + 1'b1;
      opc   = ins[7:5];
      memop = ins[4];
      rd    = ins[3:2];
      ra    = ins[1:0];
      rep.ins = ins;
      if (opc == OP_MOVE) begin
        if (!memop) begin
          regs_q[rd] = regs_q[ra];
        end else begin
          b = take_operand(ra);
          regs_q[rd] = (regs_q[rd] << 8) | reg_t'(b);
        end
      end else if (opc == OP_PUSH) begin
        if (!memop) begin
          regs_q[rd] = regs_q[rd] - 1'b1;
          rep.waddr = 16'(regs_q[rd]);
          rep.wdata = regs_q[ra][7:0];
          regs_q[ra] = regs_q[ra] >> 8;
        end else begin
          b = take_operand(ra);
          regs_q[rd] = regs_q[rd] - 1'b1;
          rep.waddr = 16'(regs_q[rd]);
          rep.wdata = b;
        end
        mem_q[reg_t'(rep.waddr)] = rep.wdata;
        rep.wrote = 1'b1;
      end else begin
        b  = memop ? take_operand(ra) : regs_q[ra][7:0];
        sb = {{(REG_BITS-8){b[7]}}, b};
        case (opc)
          OP_CSUBZ: begin
            if (regs_q[0][7:0] == 8'h00) regs_q[rd] = regs_q[rd] - sb;
          end
          OP_CSUBNZ: begin
            if (regs_q[0][7:0] != 8'h00) regs_q[rd] = regs_q[rd] - sb;
          end
          OP_AND: regs_q[rd] = regs_q[rd] & {{(REG_BITS-8){1'b1}}, b};
          OP_XOR: regs_q[rd] = regs_q[rd] ^ reg_t'(b);
          OP_ADD: regs_q[rd] = regs_q[rd] + sb;
          default: regs_q[rd] = regs_q[rd] - sb;
        endcase
      end
    end
    pc = regs_q[3];
    rep.halted = (mem_q[pc] == HALT_B0) && (mem_q[pc + 1'b1] == HALT_B1);
    rep.pc = 16'(pc);
    step_reports_q.push_back(rep);
  endtask

  always @(posedge clk_i) begin : watch
    step_report_t seen;
    step_report_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        seen = '{halted_i, program_counter_i, instruction_i, wrote_memory_i,
                 write_address_i, write_data_i};
        last_pc_o <= program_counter_i;
        if (step_reports_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result item: halt=%0b pc=%h ins=%h wr=%0b waddr=%h wdata=%h",
                     $time, seen.halted, seen.pc, seen.ins, seen.wrote, seen.waddr, seen.wdata);
          fail_count++;
        end else begin
          want = step_reports_q.pop_front();
          if (seen.halted !== want.halted || seen.pc !== want.pc || seen.ins !== want.ins ||
              seen.wrote !== want.wrote || seen.waddr !== want.waddr ||
              seen.wdata !== want.wdata) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch, expected halt=%0b pc=%h ins=%h wr=%0b waddr=%h wdata=%h",
                       $time, want.halted, want.pc, want.ins, want.wrote, want.waddr,
                       want.wdata);
              $display("%0t:           actual halt=%0b pc=%h ins=%h wr=%0b waddr=%h wdata=%h",
                       $time, seen.halted, seen.pc, seen.ins, seen.wrote, seen.waddr,
                       seen.wdata);
            end
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) run_machine_step(operation_i, load_address_i, load_byte_i);
    end
    fail_count_o <= fail_count;
    pending_o    <= step_reports_q.size();
  end

endmodule

### tb/byte_machine_step_test.sv
`timescale 1ns / 1ps

module byte_machine_step_test;
  import bms_pkg::*;

  localparam int DIRECTED_LEN = 10;
  // move-in, push, push from memory, subtract on zero taken and not, subtract on
  // nonzero taken, and, xor, add with pc as operand, sub of a reg from itself
  localparam byte_t DIRECTED_PROG [DIRECTED_LEN] = '{
    8'h12, 8'h24, 8'h35, 8'h41, 8'h61, 8'h50, 8'h85, 8'hA6, 8'hC3, 8'hE0
  };

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        operation_i    = 1'b0;
  logic [15:0] load_address_i = '0;
  logic [7:0]  load_byte_i    = '0;
  logic        out_stall_i    = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        halted_o;
  logic [15:0] program_counter_o;
  logic [7:0]  instruction_o;
  logic        wrote_memory_o;
  logic [15:0] write_address_o;
  logic [7:0]  write_data_o;

  int          fail_count;
  int          pending;
  logic [15:0] last_pc;

  int   send_idle = 38;
  int   recv_idle = 62;
  int   items_sent = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  always #5 clk_i = ~clk_i;

  byte_machine_step u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .load_address_i    (load_address_i),
    .load_byte_i       (load_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .halted_o          (halted_o),
    .program_counter_o (program_counter_o),
    .instruction_o     (instruction_o),
    .wrote_memory_o    (wrote_memory_o),
    .write_address_o   (write_address_o),
    .write_data_o      (write_data_o)
  );

  byte_machine_step_checker u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .operation_i       (operation_i),
    .load_address_i    (load_address_i),
    .load_byte_i       (load_byte_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .halted_i          (halted_o),
    .program_counter_i (program_counter_o),
    .instruction_i     (instruction_o),
    .wrote_memory_i    (wrote_memory_o),
    .write_address_i   (write_address_o),
    .write_data_i      (write_data_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .last_pc_o         (last_pc)
  );

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left   <= 120;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send_item(input logic op, input logic [15:0] addr, input byte_t data);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    load_address_i <= addr;
    load_byte_i    <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic exec_item();
    send_item(1'b1, 16'($urandom), 8'($urandom));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    #5_000_000;
    $display("FAIL byte_machine_step");
    $finish;
  end

  initial begin : stimulus
    int          n;
    logic [15:0] base;
    byte_t       ins;
    logic        pressure_done;
    logic        pressure_now;
    pressure_done = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme load, every op, halt pattern, execute while halted
    send_item(1'b0, 16'hFFFF, 8'hFF);
    for (int i = 0; i < DIRECTED_LEN; i++) send_item(1'b0, 16'(i), DIRECTED_PROG[i]);
    repeat (DIRECTED_LEN) exec_item();
    send_item(1'b0, 16'(DIRECTED_LEN), HALT_B0);
    send_item(1'b0, 16'(DIRECTED_LEN + 1), HALT_B1);
    repeat (2) exec_item();

    while (items_sent < 725) begin
      if (items_sent < 260) begin
        send_idle = 38;
        recv_idle <= 62;
      end else if (items_sent < 490) begin
        send_idle = 62;
        recv_idle <= 38;
      end else begin
        send_idle = 0;
        recv_idle <= 0;
      end
      pressure_now = (items_sent >= 490) && !pressure_done;
      wait_drain();
      base = last_pc;
      if (pressure_now || $urandom_range(99) < 80) begin
        // program at pc, then run it
        n = pressure_now ? 12 : $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          ins = 8'($urandom);
          if (ins[3:2] == 2'd3 && $urandom_range(3) != 0) ins[3:2] = 2'($urandom_range(2));
          send_item(1'b0, base + 16'(i), ins);
        end
        if ($urandom_range(99) < 25) begin
          send_item(1'b0, base + 16'(n), HALT_B0);
          send_item(1'b0, base + 16'(n + 1), HALT_B1);
        end
        repeat ($urandom_range(0, 3)) send_item(1'b0, 16'($urandom), 8'($urandom));
        if (pressure_now) begin
          in_valid_i <= 1'b0;
          hold_req   <= 1'b1;
          @(posedge clk_i);
          hold_req <= 1'b0;
          pressure_done = 1'b1;
        end
        repeat (n + $urandom_range(0, 2)) exec_item();
      end else begin
        repeat ($urandom_range(1, 8)) send_item(1'($urandom), 16'($urandom), 8'($urandom));
      end
    end

    wait_drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS byte_machine_step");
    end else begin
      $display("FAIL byte_machine_step");
    end
    $finish;
  end

endmodule
